### rtl/rkba_pkg.sv
// Shared types and constants for the radial k-bin averaging block.
// No dependencies; imported by every module of the block.
`default_nettype none

package rkba_pkg;

  // Fixed geometry limits and field widths
  localparam int unsigned NumBins = 32;
  localparam int unsigned NpixMax = 256;
  localparam int unsigned DimsMax = 3;
  localparam int unsigned EdgeW   = 32;
  localparam int unsigned SampleW = 32;
  localparam int unsigned SumW    = 56;
  localparam int unsigned CntW    = 25;
  localparam int unsigned AvgW    = 32;
  localparam int unsigned FoldW   = 8;
  localparam int unsigned SqW     = 16;
  localparam int unsigned ProdW   = SqW + 32;
  localparam int unsigned K2W     = 48;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_NUM_DIMS = 3'd0,
    REG_NPIX_A   = 3'd1,
    REG_NPIX_B   = 3'd2,
    REG_NPIX_C   = 3'd3,
    REG_KF_A     = 3'd4,
    REG_KF_B     = 3'd5,
    REG_KF_C     = 3'd6,
    REG_NUM_BINS = 3'd7
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SCALE,
    ST_SUM,
    ST_ACCUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CLEAR
  } state_e;

  // Broadcast control for the row of bin cells
  typedef struct packed {
    logic                      acc;
    logic                      shift;
    logic                      clear;
    logic                      dbl;
    logic signed [SampleW-1:0] sample;
    logic [K2W-1:0]            k2;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/rkba_cell.sv
// One bin cell: holds the lower edge, the running sum and the count of one bin.
// Depends on rkba_pkg; cells are chained by the top level.
`default_nettype none

module rkba_cell import rkba_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic             active_i,
  input  wire logic             edge_we_i,
  input  wire logic [EdgeW-1:0] edge_i,
  input  wire logic [EdgeW-1:0] hi_edge_i,
  output logic      [EdgeW-1:0] lo_edge_o,
  input  wire logic             taken_i,
  output logic                  taken_o,
  input  wire logic [SumW-1:0]  sum_i,
  input  wire logic [CntW-1:0]  cnt_i,
  output logic      [SumW-1:0]  sum_o,
  output logic      [CntW-1:0]  cnt_o
);

  logic [EdgeW-1:0] edge_q;
  logic [SumW-1:0]  sum_q, sum_d, addend;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_inc;
  logic             hit;

  // Hold the lower edge; written once per edge beat
  always_ff @(posedge clk_i) begin
    if (edge_we_i) begin
      edge_q <= edge_i;
    end
  end

  // Half-open test; the first cell that matches claims the point
  always_comb begin
    hit = active_i && !taken_i &&
          ({{(K2W-EdgeW){1'b0}}, edge_q} <= ctrl_i.k2) &&
          (ctrl_i.k2 < {{(K2W-EdgeW){1'b0}}, hi_edge_i});
    taken_o = taken_i | hit;
  end

  // Weighted addends: weight two doubles the sample
  always_comb begin
    addend  = {{(SumW-SampleW){ctrl_i.sample[SampleW-1]}}, ctrl_i.sample};
    if (ctrl_i.dbl) begin
      addend = {addend[SumW-2:0], 1'b0};
    end
    cnt_inc = {{(CntW-2){1'b0}}, ctrl_i.dbl, !ctrl_i.dbl};
  end

  // Clear, shift towards cell zero, or accumulate
  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.shift) begin
      sum_d = sum_i;
      cnt_d = cnt_i;
    end else if (ctrl_i.acc && hit) begin
      sum_d = sum_q + addend;
      cnt_d = cnt_q + cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  assign lo_edge_o = edge_q;
  assign sum_o     = sum_q;
  assign cnt_o     = cnt_q;

endmodule

`default_nettype wire

### rtl/rkba_div.sv
// Bit-serial rounded divider: signed sum over count, saturated to Q16.16.
// Depends on rkba_pkg; one quotient bit per cycle.
`default_nettype none

module rkba_div import rkba_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SumW-1:0] sum_i,
  input  wire logic [CntW-1:0] cnt_i,
  output logic                 done_o,
  output logic      [AvgW-1:0] avg_o
);

  localparam int unsigned DvdW  = SumW + 1;
  localparam int unsigned IterW = $clog2(DvdW);

  logic             busy_q, done_q;
  logic [IterW-1:0] iter_q;
  logic             neg_q, zero_q;
  logic [CntW-1:0]  cnt_q, rem_q;
  logic [DvdW-1:0]  dvd_q, quo_q;
  logic [SumW-1:0]  mag;
  logic [CntW:0]    trial;
  logic             ge;

  // Magnitude plus half the divisor gives round-half-away
  assign mag   = sum_i[SumW-1] ? (~sum_i + 1'b1) : sum_i;
  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign ge    = trial >= {1'b0, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      iter_q <= IterW'(DvdW - 1);
    end else if (busy_q) begin
      iter_q <= iter_q - 1'b1;
      if (iter_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Shift in one dividend bit and subtract where it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= sum_i[SumW-1];
      zero_q <= (cnt_i == '0);
      cnt_q  <= cnt_i;
      rem_q  <= '0;
      quo_q  <= '0;
      dvd_q  <= {1'b0, mag} + {{(DvdW-CntW+1){1'b0}}, cnt_i[CntW-1:1]};
    end else if (busy_q) begin
      rem_q  <= ge ? CntW'(trial - {1'b0, cnt_q}) : CntW'(trial);
      quo_q  <= {quo_q[DvdW-2:0], ge};
      dvd_q  <= {dvd_q[DvdW-2:0], 1'b0};
    end
  end

  // Saturate and restore the sign
  always_comb begin
    if (zero_q) begin
      avg_o = '0;
    end else if (neg_q) begin
      if ((|quo_q[DvdW-1:AvgW]) || (quo_q[AvgW-1] && (|quo_q[AvgW-2:0]))) begin
        avg_o = {1'b1, {(AvgW-1){1'b0}}};
      end else begin
        avg_o = ~quo_q[AvgW-1:0] + 1'b1;
      end
    end else if (|quo_q[DvdW-1:AvgW-1]) begin
      avg_o = {1'b0, {(AvgW-1){1'b1}}};
    end else begin
      avg_o = quo_q[AvgW-1:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

### rtl/radial_kbin_average_unit.sv
// Top level of the radial k-bin averaging block: grid walker, k2 pipeline,
// row of bin cells and serial divider. Depends on rkba_pkg, rkba_cell, rkba_div.
//
//   port group | dir | handshake         | beat carries
//   in         | in  | in_valid/in_stall | func, edge_index, edge_value, sample_value
//   out        | out | out_valid/stall   | bin_number, bin_average, bin_count, last_bin
//   cfg        | in  | cfg_we            | cfg_index, cfg_data
//
// An edge beat writes one edge register; a sample beat passes through fold, square,
// scale, sum and accumulate in the cell row. After the final grid point each bin
// passes through the serial divider (57 quotient bits), and a clear step ends the run.
// Reset loads configuration defaults and clears sums, counts and position, not edges.
// A stalled output holds the divider and the cell row until the beat is taken.
`default_nettype none

module radial_kbin_average_unit import rkba_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                func_i,
  input  wire logic [5:0]          edge_index_i,
  input  wire logic [EdgeW-1:0]    edge_value_i,
  input  wire logic signed [31:0]  sample_value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [4:0]               bin_number_o,
  output logic signed [AvgW-1:0]   bin_average_o,
  output logic [CntW-1:0]          bin_count_o,
  output logic                     last_bin_o
);

  // Configuration registers
  logic [1:0]  num_dims_q;
  logic [8:0]  npix_q [DimsMax];
  logic [31:0] kf_q   [DimsMax];
  logic [5:0]  num_bins_q;

  // Clamped configuration
  logic [1:0]  dims_c;
  logic [8:0]  n_c [DimsMax];
  logic [5:0]  nb_c;

  // Grid walker
  logic [FoldW-1:0] pos_q [DimsMax];
  logic [FoldW-1:0] pos_d [DimsMax];
  logic [FoldW-1:0] fold  [DimsMax];
  logic             at_end [DimsMax];
  logic             dbl, final_pt;

  // k2 pipeline
  logic [FoldW-1:0]   fold_q [DimsMax];
  logic [SqW-1:0]     fsq_q  [DimsMax];
  logic [ProdW-1:0]   prod_q [DimsMax];
  logic [K2W-1:0]     k2_q;
  logic               dbl_q, final_q;
  logic signed [31:0] sample_q;

  // Control
  state_e     state_q, state_d;
  logic       in_beat, edge_we, out_free, load, div_start, div_done;
  logic [4:0] bin_q;
  logic       last_c;
  cell_ctrl_t ctrl;
  logic [AvgW-1:0] div_avg;

  // Cell row wiring
  logic [EdgeW-1:0] edge_top_q;
  logic [EdgeW-1:0] lo_edge [NumBins];
  logic             taken   [NumBins+1];
  logic [SumW-1:0]  sum_row [NumBins+1];
  logic [CntW-1:0]  cnt_row [NumBins+1];

  assign in_beat  = in_valid_i && !in_stall_o;
  assign edge_we  = in_beat && !func_i;
  assign out_free = !out_valid_o || !out_stall_i;

  // Write configuration; geometry writes restart the grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= 2'd3;
      num_bins_q <= 6'd32;
      for (int a = 0; a < DimsMax; a++) begin
        npix_q[a] <= 9'd256;
        kf_q[a]   <= 32'd65536;
      end
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_NUM_DIMS: num_dims_q <= cfg_data_i[1:0];
        REG_NPIX_A:   npix_q[0]  <= cfg_data_i[8:0];
        REG_NPIX_B:   npix_q[1]  <= cfg_data_i[8:0];
        REG_NPIX_C:   npix_q[2]  <= cfg_data_i[8:0];
        REG_KF_A:     kf_q[0]    <= cfg_data_i;
        REG_KF_B:     kf_q[1]    <= cfg_data_i;
        REG_KF_C:     kf_q[2]    <= cfg_data_i;
        REG_NUM_BINS: num_bins_q <= cfg_data_i[5:0];
        default:      num_dims_q <= num_dims_q;
      endcase
    end
  end

  // Clamp registers into range
  always_comb begin
    dims_c = (num_dims_q == 2'd0) ? 2'd1 : num_dims_q;
    nb_c   = (num_bins_q == 6'd0) ? 6'd1 :
             (num_bins_q > 6'(NumBins)) ? 6'(NumBins) : num_bins_q;
    for (int a = 0; a < DimsMax; a++) begin
      n_c[a] = (npix_q[a] == 9'd0) ? 9'd1 :
               (npix_q[a] > 9'(NpixMax)) ? 9'(NpixMax) : npix_q[a];
    end
  end

  // Fold indexes, find the weight and the final point, advance the odometer
  always_comb begin
    logic       carry;
    logic [8:0] ext;
    logic [8:0] mirror;
    dbl      = 1'b0;
    final_pt = 1'b1;
    carry    = 1'b1;
    for (int a = 0; a < DimsMax; a++) begin
      ext       = (a == int'(dims_c) - 1) ? ((n_c[a] >> 1) + 9'd1) : n_c[a];
      mirror    = n_c[a] - {1'b0, pos_q[a]};
      at_end[a] = ({1'b0, pos_q[a]} + 9'd1) == ext;
      fold[a]   = '0;
      if (a < int'(dims_c)) begin
        if (a == int'(dims_c) - 1) begin
          fold[a] = pos_q[a];
          dbl     = !((pos_q[a] == '0) || ({pos_q[a], 1'b0} == n_c[a]));
        end else begin
          fold[a] = ({1'b0, pos_q[a]} < mirror) ? pos_q[a] : FoldW'(mirror);
        end
        final_pt = final_pt && at_end[a];
      end
    end
    for (int a = DimsMax - 1; a >= 0; a--) begin
      pos_d[a] = pos_q[a];
      if (a < int'(dims_c) && carry) begin
        if (at_end[a]) begin
          pos_d[a] = '0;
        end else begin
          pos_d[a] = pos_q[a] + 1'b1;
          carry    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < DimsMax; a++) pos_q[a] <= '0;
    end else if (cfg_we_i && (reg_idx_e'(cfg_index_i) == REG_NUM_DIMS ||
                              reg_idx_e'(cfg_index_i) == REG_NPIX_A ||
                              reg_idx_e'(cfg_index_i) == REG_NPIX_B ||
                              reg_idx_e'(cfg_index_i) == REG_NPIX_C)) begin
      for (int a = 0; a < DimsMax; a++) pos_q[a] <= '0;
    end else if (in_beat && func_i) begin
      for (int a = 0; a < DimsMax; a++) pos_q[a] <= pos_d[a];
    end
  end

  // Capture the sample beat
  always_ff @(posedge clk_i) begin
    if (in_beat && func_i) begin
      sample_q <= sample_value_i;
      dbl_q    <= dbl;
      final_q  <= final_pt;
      for (int a = 0; a < DimsMax; a++) fold_q[a] <= fold[a];
    end
  end

  // Square, scale by kf, then sum the axes
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < DimsMax; a++) begin
      fsq_q[a]  <= SqW'(fold_q[a] * fold_q[a]);
      prod_q[a] <= ProdW'(fsq_q[a] * kf_q[a]);
    end
    k2_q <= K2W'(prod_q[0]) + K2W'(prod_q[1]) + K2W'(prod_q[2]);
  end

  // Hold the top edge, which closes the last bin
  always_ff @(posedge clk_i) begin
    if (edge_we && edge_index_i == 6'(NumBins)) begin
      edge_top_q <= edge_value_i;
    end
  end

  // Row of bin cells; sums and counts shift towards cell zero on emit
  assign taken[0]         = 1'b0;
  assign sum_row[NumBins] = '0;
  assign cnt_row[NumBins] = '0;

  for (genvar b = 0; b < NumBins; b++) begin : g_cell
    localparam logic [5:0] Idx = 6'(b);
    logic [EdgeW-1:0] hi_edge;
    if (b == NumBins - 1) begin : g_top
      assign hi_edge = edge_top_q;
    end else begin : g_mid
      assign hi_edge = lo_edge[b+1];
    end
    rkba_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .active_i  (Idx < nb_c),
      .edge_we_i (edge_we && edge_index_i == Idx),
      .edge_i    (edge_value_i),
      .hi_edge_i (hi_edge),
      .lo_edge_o (lo_edge[b]),
      .taken_i   (taken[b]),
      .taken_o   (taken[b+1]),
      .sum_i     (sum_row[b+1]),
      .cnt_i     (cnt_row[b+1]),
      .sum_o     (sum_row[b]),
      .cnt_o     (cnt_row[b])
    );
  end

  rkba_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_row[0]),
    .cnt_i   (cnt_row[0]),
    .done_o  (div_done),
    .avg_o   (div_avg)
  );

  assign last_c = ({1'b0, bin_q} + 6'd1) == nb_c;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_beat && func_i) state_d = ST_SQUARE;
      ST_SQUARE:   state_d = ST_SCALE;
      ST_SCALE:    state_d = ST_SUM;
      ST_SUM:      state_d = ST_ACCUM;
      ST_ACCUM:    state_d = final_q ? ST_DIV_GO : ST_IDLE;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done && out_free) state_d = last_c ? ST_CLEAR : ST_DIV_GO;
      ST_CLEAR:    state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    div_start   = (state_q == ST_DIV_GO);
    load        = (state_q == ST_DIV_WAIT) && div_done && out_free;
    ctrl.acc    = (state_q == ST_ACCUM);
    ctrl.shift  = load;
    ctrl.clear  = (state_q == ST_CLEAR);
    ctrl.dbl    = dbl_q;
    ctrl.sample = sample_q;
    ctrl.k2     = k2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bin_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl.clear) begin
        bin_q <= '0;
      end else if (load) begin
        bin_q <= bin_q + 1'b1;
      end
    end
  end

  // Output register; drop valid once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bin_number_o  <= bin_q;
      bin_average_o <= div_avg;
      bin_count_o   <= cnt_row[0];
      last_bin_o    <= last_c;
    end
  end

endmodule

`default_nettype wire

### rtl/rkba_checker.sv
// Port-level checks for radial_kbin_average_unit, bound to the top level.
// Depends on rkba_pkg for field widths.
`default_nettype none

module rkba_checker import rkba_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_we_i,
  input wire logic [2:0]         cfg_index_i,
  input wire logic [31:0]        cfg_data_i,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               func_i,
  input wire logic [5:0]         edge_index_i,
  input wire logic [EdgeW-1:0]   edge_value_i,
  input wire logic [31:0]        sample_value_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [4:0]         bin_number_o,
  input wire logic [AvgW-1:0]    bin_average_o,
  input wire logic [CntW-1:0]    bin_count_o,
  input wire logic               last_bin_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bin_average_o) &&
                                   $stable(bin_count_o) && $stable(bin_number_o))
    else $error("stalled result beat changed");

  // An empty bin reports a zero average
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bin_count_o == '0 |-> bin_average_o == '0)
    else $error("empty bin with nonzero average");

  // The last bin of a run is not followed at once by another result
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_bin_o |=> !out_valid_o)
    else $error("result beat right after the last bin");

  // The highest bin number can only close a run
  a_top_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bin_number_o == 5'd31 |-> last_bin_o)
    else $error("bin 31 not flagged as the last bin");

endmodule

bind radial_kbin_average_unit rkba_checker u_rkba_checker (.*);

`default_nettype wire
